// ===== rtl/sha512_pkg.sv =====
// Package for the SHA-512 hash engine: constants and the round-constant table.
// No dependencies.
package sha512_pkg;

  localparam int WordW = 64;

  localparam logic [WordW-1:0] PadWord = 64'h8000000000000000;

  localparam logic [WordW-1:0] InitChain [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam logic [WordW-1:0] RoundConst [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

endpackage

// ===== rtl/sha512_hash_engine.sv =====
// SHA-512 hash engine top level: padding sequencer, one shared round unit,
// schedule window and digest output register. Depends on sha512_pkg.
//
// Usage: message words enter on the in_ stream, big-endian, eight bytes each.
// in_tdata carries the word and its valid byte count, in_tlast marks the
// final word (which may hold 0 to 8 valid bytes; counts above 8 act as 8).
// On the final word the block pads the message, runs the remaining blocks and
// then sends eight digest words on the out_ stream, most significant first,
// with out_tlast on the eighth. The chain then returns to the initial value.
// Operation: a word that does not complete a block is written to the window. A word that
// completes a 16-word block runs the rounds on the single shared round unit,
// one round per cycle, and then folds the result into the chain. A last
// word pushes its padding words one per cycle and compresses one or two
// blocks, then the digest follows. No input word is taken during rounds,
// folding or padding. Reset clears the sequencer and length and reloads the
// initial chain; the schedule window is not cleared. When out_tready is low
// the current digest word holds and the block waits; no new request is taken
// until all eight words are delivered.
module sha512_hash_engine
  import sha512_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [63:0] data_word, [67:64] byte_count, [71:68] zero
  input  logic        in_tlast,   // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [63:0] digest_word, [66:64] word_index, [71:67] zero
  output logic        out_tlast   // digest_last
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StFold  = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0]   state_r, state_nxt;
  logic [63:0]  chain_r [8];
  logic [63:0]  work_r [8];
  logic [63:0]  win_r [16];
  logic [3:0]   wib_r;
  logic [127:0] len_r;
  logic [6:0]   rnd_r;
  logic [1:0]   phase_r;  // 0 data, 1 zero fill, 2 length high, 3 length low
  logic         final_r;  // message ended; digest follows the fold of the last block
  logic [2:0]   oidx_r;
  logic [63:0]  pend_r;   // second word of a full last word
  logic         pend_v_r;

  logic         in_fire;
  logic [3:0]   n_sat;
  logic [63:0]  first_word;
  logic [63:0]  keep;
  logic [5:0]   shamt;

  assign in_tready = (state_r == StIdle);
  assign in_fire   = in_tvalid && in_tready;
  assign n_sat     = (in_tdata[67:64] > 4'd8) ? 4'd8 : in_tdata[67:64];
  assign shamt     = {n_sat[2:0], 3'b000};
  assign keep      = ~({64{1'b1}} >> shamt);

  always_comb begin
    if (n_sat == 4'd8)      first_word = in_tdata[63:0];
    else if (n_sat == 4'd0) first_word = PadWord;
    else first_word = (in_tdata[63:0] & keep) | (64'h80 << (6'd56 - shamt));
  end

  // Round unit.
  logic [63:0] x2, x15, x7, x16, s0, s1, wnew, w, t1, t2, e, a;
  logic [3:0]  ri;
  assign ri   = rnd_r[3:0];
  assign x2   = win_r[ri - 4'd2];
  assign x15  = win_r[ri - 4'd15];
  assign x7   = win_r[ri - 4'd7];
  assign x16  = win_r[ri];
  assign s1   = {x2[18:0], x2[63:19]} ^ {x2[60:0], x2[63:61]} ^ (x2 >> 6);
  assign s0   = {x15[0], x15[63:1]} ^ {x15[7:0], x15[63:8]} ^ (x15 >> 7);
  assign wnew = x16 + s1 + x7 + s0;
  assign w    = (rnd_r >= 7'd16) ? wnew : x16;
  assign e    = work_r[4];
  assign a    = work_r[0];
  assign t1 = work_r[7] + ({e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]})
            + ((e & work_r[5]) ^ (~e & work_r[6])) + RoundConst[rnd_r] + w;
  assign t2 = ({a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]})
            + ((a & work_r[1]) ^ (a & work_r[2]) ^ (work_r[1] & work_r[2]));

  // Word pushed by the padding sequencer in StPad.
  logic [63:0] pad_word;
  always_comb begin
    if (pend_v_r)            pad_word = pend_r;
    else if (phase_r == 2'd2) pad_word = len_r[127:64];
    else if (phase_r == 2'd3) pad_word = len_r[63:0];
    else                      pad_word = '0;
  end

  logic        push;
  logic [63:0] push_word;
  always_comb begin
    push = 1'b0;
    push_word = pad_word;
    if (state_r == StIdle && in_fire) begin
      push = 1'b1;
      push_word = in_tlast ? first_word : in_tdata[63:0];
    end else if (state_r == StPad) begin
      push = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      StIdle:  if (in_fire) state_nxt = (wib_r == 4'd15) ? StRound : (in_tlast ? StPad : StIdle);
      StPad:   if (wib_r == 4'd15) state_nxt = StRound;
      StRound: if (rnd_r == 7'd79) state_nxt = StFold;
      StFold: begin
        if (final_r && phase_r == 2'd0) state_nxt = StOut;
        else if (final_r) state_nxt = StPad;
        else state_nxt = StIdle;
      end
      StOut:   if (out_tready && oidx_r == 3'd7) state_nxt = StIdle;
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      win_r[wib_r] <= push_word;
    end else if (state_r == StRound) begin
      win_r[ri] <= w;
    end
    if (state_r == StRound) begin
      work_r[7] <= work_r[6]; work_r[6] <= work_r[5]; work_r[5] <= work_r[4];
      work_r[4] <= work_r[3] + t1;
      work_r[3] <= work_r[2]; work_r[2] <= work_r[1]; work_r[1] <= work_r[0];
      work_r[0] <= t1 + t2;
    end else if (push && wib_r == 4'd15) begin
      for (int i = 0; i < 8; i++) work_r[i] <= chain_r[i];
    end
    if (state_r == StIdle && in_fire && in_tlast && n_sat == 4'd8) pend_r <= PadWord;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= StIdle;
      for (int i = 0; i < 8; i++) chain_r[i] <= InitChain[i];
      wib_r    <= '0;
      len_r    <= '0;
      rnd_r    <= '0;
      phase_r  <= '0;
      final_r  <= 1'b0;
      oidx_r   <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (push) wib_r <= wib_r + 4'd1;
      if (state_r == StIdle && in_fire) begin
        len_r <= len_r + {121'd0, (in_tlast ? n_sat : 4'd8), 3'd0};
        if (in_tlast) begin
          final_r  <= 1'b1;
          // A partial last word in slot 13 leaves no room for zero fill.
          phase_r  <= (n_sat != 4'd8 && wib_r == 4'd13) ? 2'd2 : 2'd1;
          pend_v_r <= (n_sat == 4'd8);
        end
      end
      if (state_r == StPad) begin
        if (pend_v_r) pend_v_r <= 1'b0;
        else if (phase_r == 2'd3) phase_r <= 2'd0;
        else if (phase_r == 2'd2) phase_r <= 2'd3;
        // Zero fill ends when the next free slot is the length high word.
        if (phase_r == 2'd1 && wib_r == 4'd13) phase_r <= 2'd2;
      end
      if (state_r == StRound) rnd_r <= (rnd_r == 7'd79) ? 7'd0 : rnd_r + 7'd1;
      if (state_r == StFold) begin
        for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + work_r[i];
        if (final_r && phase_r == 2'd0) oidx_r <= '0;
      end
      if (state_r == StOut && out_tready) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          for (int i = 0; i < 8; i++) chain_r[i] <= InitChain[i];
          len_r   <= '0;
          final_r <= 1'b0;
        end
      end
    end
  end

  assign out_tvalid = (state_r == StOut);
  assign out_tdata  = {5'd0, oidx_r, chain_r[oidx_r]};
  assign out_tlast  = (oidx_r == 3'd7);

endmodule

// ===== sim/sha512_hash_engine_test.sv =====
// Self-checking bench for sha512_hash_engine: drives message words on the in_ stream,
// predicts the SHA-512 digest in-bench and checks the eight out_ words.
// Depends on sha512_pkg and the sha512_hash_engine RTL.
module sha512_hash_engine_test;
  import sha512_pkg::*;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last_word;
  } msg_word_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } digest_out_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        out_tlast;

  sha512_hash_engine DUT (.*);

  // Predictor state.
  logic [63:0]  chain_q [8];
  logic [63:0]  sched_q [16];
  int unsigned  fill_cnt;
  logic [127:0] bit_len;

  msg_word_t   pending_words [$];
  digest_out_t digest_expect [$];
  idle_mode_t  idle_mode;
  int          fail_cnt;
  int          msg_cnt;
  int          digest_cnt;
  bit          hold_send;

  function automatic logic [63:0] ror(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic void run_rounds();
    logic [63:0] v [8];
    logic [63:0] w, t1, t2, x2, x15;
    for (int i = 0; i < 8; i++) v[i] = chain_q[i];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        x2  = sched_q[(r - 2) & 15];
        x15 = sched_q[(r - 15) & 15];
        sched_q[r & 15] += (ror(x2, 19) ^ ror(x2, 61) ^ (x2 >> 6)) + sched_q[(r - 7) & 15]
                           + (ror(x15, 1) ^ ror(x15, 8) ^ (x15 >> 7));
      end
      w  = sched_q[r & 15];
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + w;
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_q[i] += v[i];
  endfunction

  function automatic void load_word(logic [63:0] w);
    sched_q[fill_cnt] = w;
    fill_cnt = (fill_cnt + 1) & 15;
    if (fill_cnt == 0) run_rounds();
  endfunction

  function automatic void predict_hash(msg_word_t m);
    int unsigned n;
    logic [63:0] keep;
    digest_out_t d;
    if (!m.last_word) begin
      bit_len += 128'd64;
      load_word(m.data_word);
      return;
    end
    n = (m.byte_count > 8) ? 8 : m.byte_count;
    bit_len += 128'(n * 8);
    if (n == 8) begin
      load_word(m.data_word);
      load_word(PadWord);
    end else if (n == 0) begin
      load_word(PadWord);
    end else begin
      keep = ~(64'hffffffffffffffff >> (8 * n));
      load_word((m.data_word & keep) | (64'h80 << (56 - 8 * n)));
    end
    while (fill_cnt != 14) load_word('0);
    load_word(bit_len[127:64]);
    load_word(bit_len[63:0]);
    for (int j = 0; j < 8; j++) begin
      d.digest_word = chain_q[j];
      d.word_index  = 3'(j);
      d.digest_last = (j == 7);
      digest_expect = {digest_expect, d};
    end
    for (int i = 0; i < 8; i++) chain_q[i] = InitChain[i];
    bit_len  = '0;
    fill_cnt = 0;
  endfunction

  function automatic msg_word_t make_word(logic [63:0] dw, int bc, bit lw);
    msg_word_t m;
    m.data_word = dw; m.byte_count = 4'(bc); m.last_word = lw;
    return m;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Queues one message of nw full words followed by a last word of bc bytes.
  task automatic queue_message(int nw, int bc);
    for (int i = 0; i < nw; i++)
      pending_words = {pending_words, make_word(rand64(), ($urandom_range(0, 3) == 0) ?
                                        $urandom_range(0, 15) : 8, 1'b0)};
    pending_words = {pending_words, make_word(rand64(), bc, 1'b1)};
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_words.size() > 0 && !hold_send &&
          !((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 57) ||
            (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 38))) begin
        msg_word_t m;
        m = pending_words.pop_front();
        predict_hash(m);
        in_tvalid <= 1'b1;
        in_tdata  <= {4'b0, m.byte_count, m.data_word};
        in_tlast  <= m.last_word;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !((idle_mode == IDLE_RECV && $urandom_range(0, 99) < 57) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 38));
      if (out_tvalid && out_tready) begin
        digest_out_t got, exp;
        got.digest_word = out_tdata[63:0];
        got.word_index  = out_tdata[66:64];
        got.digest_last = out_tlast;
        digest_cnt++;
        if (digest_expect.size() == 0) begin
          $error("digest word with no request pending: %h", got.digest_word);
          fail_cnt++;
        end else begin
          exp = digest_expect.pop_front();
          if (got.digest_word !== exp.digest_word) begin
            $error("digest_word expected %h got %h", exp.digest_word, got.digest_word);
            fail_cnt++;
          end
          if (got.word_index !== exp.word_index) begin
            $error("word_index expected %0d got %0d", exp.word_index, got.word_index);
            fail_cnt++;
          end
          if (got.digest_last !== exp.digest_last) begin
            $error("digest_last expected %0d got %0d", exp.digest_last, got.digest_last);
            fail_cnt++;
          end
          if (out_tdata[71:67] !== 5'b0) begin
            $error("out_tdata pad expected 0 got %h", out_tdata[71:67]);
            fail_cnt++;
          end
        end
      end
    end
  end

  initial begin
    int wait_cnt;
    fail_cnt = 0; digest_cnt = 0; msg_cnt = 0;
    hold_send = 0; idle_mode = IDLE_NONE;
    for (int i = 0; i < 8; i++) chain_q[i] = InitChain[i];
    fill_cnt = 0; bit_len = '0;
    rst_n = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // Directed: empty message, every partial length, all-ones and all-zero words,
    // oversized counts and a spill into a second block.
    pending_words = {pending_words, make_word(rand64(), 0, 1'b1)};
    pending_words = {pending_words, make_word(64'hffffffffffffffff, 15, 1'b1)};
    pending_words = {pending_words, make_word(64'h0, 9, 1'b1)};
    for (int b = 1; b <= 8; b++)
      pending_words = {pending_words, make_word(64'hffffffffffffffff, b, 1'b1)};
    pending_words = {pending_words, make_word(64'h0, 3, 1'b0)};  // partial, not last: full word
    pending_words = {pending_words, make_word(64'hffffffffffffffff, 12, 1'b1)};
    queue_message(13, 8);
    msg_cnt = 13;

    // Random phases; the sender waits for all digests between phases.
    for (int ph = 0; ph < 4; ph++) begin
      wait (pending_words.size() == 0 && digest_expect.size() == 0);
      hold_send = 1;
      repeat (2) @(posedge clk);
      idle_mode = idle_mode_t'(ph);
      hold_send = 0;
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(0, 3))
          0: queue_message($urandom_range(0, 3), $urandom_range(0, 15));
          1: queue_message($urandom_range(12, 16), $urandom_range(0, 8));
          2: queue_message($urandom_range(17, 32), $urandom_range(0, 8));
          default: queue_message($urandom_range(4, 10), 8);
        endcase
        msg_cnt++;
      end
    end
    wait (pending_words.size() == 0 && digest_expect.size() == 0);
    idle_mode = IDLE_NONE;
    wait_cnt = 0;
    while (wait_cnt < 300) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (digest_expect.size() != 0) fail_cnt++;
    $display("Ran %0d messages and checked %0d digest words under four idling patterns.",
             msg_cnt, digest_cnt);
    if (fail_cnt == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sha512_hash_engine.f =====
rtl/sha512_pkg.sv
rtl/sha512_hash_engine.sv
sim/sha512_hash_engine_test.sv
